[sv/ss8e2_pkg.sv]
package ss8e2_pkg;

  // default width of the period / bit counter
  localparam int unsigned COUNT_BITS_DEF = 8;

  localparam int unsigned FRAME_W = 12;

  // frame checks on the captured shift word: both stops high, top bit low
  localparam logic [FRAME_W-1:0] CHECK_MASK = 12'h803;
  localparam logic [FRAME_W-1:0] CHECK_OK   = 12'h003;
  localparam int unsigned SEND_BITS    = 12;
  localparam int unsigned CAPTURE_BITS = 11;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SEND    = 3'd1,
    PH_HUNT    = 3'd2,
    PH_CAPTURE = 3'd3,
    PH_HOLD    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    MODE_SEND  = 2'd0,
    MODE_RECV  = 2'd1,
    MODE_BREAK = 2'd2,
    MODE_IDLE  = 2'd3
  } mode_e;

  localparam logic [1:0] RX_OK      = 2'd0;
  localparam logic [1:0] RX_FRAMING = 2'd1;
  localparam logic [1:0] RX_PARITY  = 2'd2;

  // state kept between periods, counter excluded (its width is a parameter)
  typedef struct packed {
    phase_e             phase;
    logic [FRAME_W-1:0] frame_shift;
    logic               held_level;
    logic               held_drive;
  } state_t;

  // one result item
  typedef struct packed {
    logic       drive_enable;
    logic       line_out;
    logic       clock_active;
    logic       ready_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [1:0] rx_status;
  } result_t;

  function automatic logic odd_ones(input logic [7:0] v);
    return ^v;
  endfunction

endpackage

[sv/ss8e2_step.sv]
module ss8e2_step import ss8e2_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  state_t                state_i,
  input  logic [COUNT_BITS-1:0] bits_left_i,
  input  logic                  cmd_valid_i,
  input  logic [1:0]            mode_i,
  input  logic [7:0]            tx_byte_i,
  input  logic [7:0]            period_count_i,
  input  logic                  line_in_i,
  output state_t                state_o,
  output logic [COUNT_BITS-1:0] bits_left_o,
  output result_t               result_o
);

  localparam int unsigned CW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam logic [CW-1:0] CNT_MAX = CW'({COUNT_BITS{1'b1}});

  logic [CW-1:0]         count_ext;
  logic [COUNT_BITS-1:0] count_sat;

  // period count saturates to what the counter holds
  always_comb begin
    count_ext = CW'(period_count_i);
    if (count_ext > CNT_MAX) begin
      count_sat = {COUNT_BITS{1'b1}};
    end else begin
      count_sat = count_ext[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    state_t                st;
    logic [COUNT_BITS-1:0] bl;
    result_t               res;
    logic                  ones;

    st   = state_i;
    bl   = bits_left_i;
    res  = '0;
    ones = 1'b0;

    // command intake, acts in the same period
    if (st.phase == PH_IDLE) begin
      res.ready_res = 1'b1;
      if (cmd_valid_i) begin
        unique case (mode_e'(mode_i))
          MODE_SEND: begin
            st.frame_shift = {2'b11, odd_ones(tx_byte_i), tx_byte_i, 1'b0};
            bl             = COUNT_BITS'(SEND_BITS);
            st.phase       = PH_SEND;
          end
          MODE_RECV: begin
            st.held_drive = 1'b0;
            st.phase      = PH_HUNT;
          end
          default: begin
            st.held_level = (mode_e'(mode_i) == MODE_IDLE);
            st.held_drive = 1'b1;
            bl            = count_sat;
            if (count_sat != '0) begin
              st.phase = PH_HOLD;
            end
          end
        endcase
      end
    end

    unique case (st.phase)
      PH_SEND: begin
        res.drive_enable = 1'b1;
        res.clock_active = 1'b1;
        res.line_out     = st.frame_shift[0];
        st.frame_shift   = {1'b0, st.frame_shift[FRAME_W-1:1]};
        bl               = bl - COUNT_BITS'(1);
        if (bl == '0) begin
          st.held_level = res.line_out;
          st.held_drive = 1'b1;
          st.phase      = PH_IDLE;
        end
      end
      PH_HUNT: begin
        res.clock_active = 1'b1;
        if (!line_in_i) begin
          st.frame_shift = '0;
          bl             = COUNT_BITS'(CAPTURE_BITS);
          st.phase       = PH_CAPTURE;
        end
      end
      PH_CAPTURE: begin
        res.clock_active = 1'b1;
        st.frame_shift   = {st.frame_shift[FRAME_W-2:0], line_in_i};
        bl               = bl - COUNT_BITS'(1);
        if (bl == '0) begin
          res.rx_valid = 1'b1;
          for (int i = 0; i < 8; i++) begin
            res.rx_byte[i] = st.frame_shift[10-i];
          end
          ones = odd_ones(res.rx_byte) ^ st.frame_shift[2];
          if ((st.frame_shift & CHECK_MASK) != CHECK_OK) begin
            res.rx_status = RX_FRAMING;
          end else if (ones) begin
            res.rx_status = RX_PARITY;
          end
          st.held_drive = 1'b0;
          st.phase      = PH_IDLE;
        end
      end
      PH_HOLD: begin
        res.drive_enable = 1'b1;
        res.clock_active = 1'b1;
        res.line_out     = st.held_level;
        bl               = bl - COUNT_BITS'(1);
        if (bl == '0) begin
          st.phase = PH_IDLE;
        end
      end
      default: begin
        st.phase         = PH_IDLE;
        res.drive_enable = st.held_drive;
        res.line_out     = st.held_drive & st.held_level;
      end
    endcase

    state_o     = st;
    bits_left_o = bl;
    result_o    = res;
  end

endmodule

[sv/sync_serial_8e2_frame_phy_core.sv]
// Bit engine of a clocked half-duplex serial link with 8E2 framing. Every
// input transaction is one bit-clock period: while the engine is idle it takes
// a command (send a byte, receive a byte, break, idle) and the command acts in
// that same period. Every input transaction yields exactly one output
// transaction carrying line drive, clock enable, readiness and any received
// byte with its status (framing error wins over parity error). Rate: one
// transaction per clock cycle, sustained; the result appears in the output
// register in the cycle after acceptance. The input side stalls only while that
// register holds a result the consumer has not taken. No clearing pass is
// needed after reset.
module sync_serial_8e2_frame_phy_core import ss8e2_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_valid_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] tx_byte_i,
  input  logic [7:0] period_count_i,
  input  logic       line_in_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       drive_enable_o,
  output logic       line_out_o,
  output logic       clock_active_o,
  output logic       ready_res_o,
  output logic       rx_valid_o,
  output logic [7:0] rx_byte_o,
  output logic [1:0] rx_status_o
);

  // link state, advanced once per accepted transaction
  state_t                state_q, state_d;
  logic [COUNT_BITS-1:0] bits_q, bits_d;

  // output register
  logic    out_valid_q;
  result_t result_q, result_d;

  logic in_fire;

  // free to take a period whenever the output register empties this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  ss8e2_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .state_i       (state_q),
    .bits_left_i   (bits_q),
    .cmd_valid_i   (cmd_valid_i),
    .mode_i        (mode_i),
    .tx_byte_i     (tx_byte_i),
    .period_count_i(period_count_i),
    .line_in_i     (line_in_i),
    .state_o       (state_d),
    .bits_left_o   (bits_d),
    .result_o      (result_d)
  );

  // state only moves on an accepted period
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= PH_IDLE;
      state_q.frame_shift <= '0;
      state_q.held_level  <= 1'b1;
      state_q.held_drive  <= 1'b1;
      bits_q              <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
      bits_q  <= bits_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_enable_o = result_q.drive_enable;
  assign line_out_o     = result_q.line_out;
  assign clock_active_o = result_q.clock_active;
  assign ready_res_o    = result_q.ready_res;
  assign rx_valid_o     = result_q.rx_valid;
  assign rx_byte_o      = result_q.rx_byte;
  assign rx_status_o    = result_q.rx_status;

endmodule

[sv/ss8e2_checker.sv]
module ss8e2_checker import ss8e2_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       cmd_valid_i,
  input logic [1:0] mode_i,
  input logic [7:0] tx_byte_i,
  input logic [7:0] period_count_i,
  input logic       line_in_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       drive_enable_o,
  input logic       line_out_o,
  input logic       clock_active_o,
  input logic       ready_res_o,
  input logic       rx_valid_o,
  input logic [7:0] rx_byte_o,
  input logic [1:0] rx_status_o
);

  // input only stalls behind a full, untaken output register
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a pending output");

  // accepted period produces a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted transaction gave no result");

  // released line reads low
  a_released_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !drive_enable_o) |-> !line_out_o)
    else $error("line_out high while released");

  // completed reception: clocked, released, legal status
  a_rx_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rx_valid_o) |->
      (clock_active_o && !drive_enable_o && !ready_res_o && rx_status_o != 2'd3))
    else $error("bad reception report");

  // no reception, no byte or status
  a_rx_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !rx_valid_o) |-> (rx_byte_o == 8'd0 && rx_status_o == RX_OK))
    else $error("byte or status without reception");

endmodule

bind sync_serial_8e2_frame_phy_core ss8e2_checker u_ss8e2_checker (.*);

[tb/ss8e2_link_checker.sv]
module ss8e2_link_checker import ss8e2_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic       cmd_valid_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] tx_byte_i,
  input  logic [7:0] period_count_i,
  input  logic       line_in_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       drive_enable_i,
  input  logic       line_out_i,
  input  logic       clock_active_i,
  input  logic       ready_res_i,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic [1:0] rx_status_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // link engine state, counter at the default 8-bit width
  phase_e             link_phase;
  logic [7:0]         bits_to_go;
  logic [FRAME_W-1:0] shift_word;
  logic               level_held;
  logic               drive_held;

  result_t expected_periods[$];
  int      mismatch_total = 0;
  int      results_seen = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
    mismatch_total++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic predict_period(input logic cmd, input mode_e md, input logic [7:0] data,
                                input logic [7:0] cnt, input logic sample,
                                output result_t res);
    logic       level;
    logic [7:0] rx;
    res = '0;
    level = 1'b0;
    rx = '0;
    if (link_phase == PH_IDLE) begin
      res.ready_res = 1'b1;
      if (cmd) begin
        case (md)
          MODE_SEND: begin
            // start low, data lsb first, even parity, two stops
            shift_word = {2'b11, ^data, data, 1'b0};
            bits_to_go = 8'(SEND_BITS);
            link_phase = PH_SEND;
          end
          MODE_RECV: begin
            drive_held = 1'b0;
            link_phase = PH_HUNT;
          end
          default: begin
            level_held = (md == MODE_IDLE);
            drive_held = 1'b1;
            bits_to_go = cnt;
            if (cnt != 8'd0) link_phase = PH_HOLD;
          end
        endcase
      end
    end
    case (link_phase)
      PH_SEND: begin
        res.drive_enable = 1'b1;
        res.clock_active = 1'b1;
        level = shift_word[0];
        shift_word = shift_word >> 1;
        bits_to_go = bits_to_go - 8'd1;
        if (bits_to_go == 8'd0) begin
          level_held = level;
          drive_held = 1'b1;
          link_phase = PH_IDLE;
        end
        res.line_out = level;
      end
      PH_HUNT: begin
        res.clock_active = 1'b1;
        if (!sample) begin
          shift_word = '0;
          bits_to_go = 8'(CAPTURE_BITS);
          link_phase = PH_CAPTURE;
        end
      end
      PH_CAPTURE: begin
        res.clock_active = 1'b1;
        shift_word = {shift_word[FRAME_W-2:0], sample};
        bits_to_go = bits_to_go - 8'd1;
        if (bits_to_go == 8'd0) begin
          res.rx_valid = 1'b1;
          for (int i = 0; i < 8; i++) rx[i] = shift_word[10-i];
          res.rx_byte = rx;
          if ((shift_word & CHECK_MASK) != CHECK_OK) res.rx_status = RX_FRAMING;
          else if (^rx ^ shift_word[2]) res.rx_status = RX_PARITY;
          drive_held = 1'b0;
          link_phase = PH_IDLE;
        end
      end
      PH_HOLD: begin
        res.drive_enable = 1'b1;
        res.clock_active = 1'b1;
        res.line_out = level_held;
        bits_to_go = bits_to_go - 8'd1;
        if (bits_to_go == 8'd0) link_phase = PH_IDLE;
      end
      default: begin
        link_phase = PH_IDLE;
        res.drive_enable = drive_held;
        res.line_out = drive_held & level_held;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      link_phase = PH_IDLE;
      bits_to_go = '0;
      shift_word = '0;
      level_held = 1'b1;
      drive_held = 1'b1;
      expected_periods.delete();
      pending_o <= 0;
      fail_count_o <= mismatch_total;
    end else begin
      // output side first: check a result as it leaves
      if (out_valid_i && out_ready_i) begin
        seen = {drive_enable_i, line_out_i, clock_active_i, ready_res_i,
                rx_valid_i, rx_byte_i, rx_status_i};
        if (expected_periods.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_periods.pop_front();
          compare_field("drive_enable", seen.drive_enable, want.drive_enable);
          compare_field("line_out", seen.line_out, want.line_out);
          compare_field("clock_active", seen.clock_active, want.clock_active);
          compare_field("ready_res", seen.ready_res, want.ready_res);
          compare_field("rx_valid", seen.rx_valid, want.rx_valid);
          compare_field("rx_byte", seen.rx_byte, want.rx_byte);
          compare_field("rx_status", seen.rx_status, want.rx_status);
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        predict_period(cmd_valid_i, mode_e'(mode_i), tx_byte_i, period_count_i, line_in_i, want);
        expected_periods.push_back(want);
      end
      pending_o <= expected_periods.size();
      fail_count_o <= mismatch_total;
    end
  end

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ss8e2_pkg::*;

  // random part length in bit periods, and the watchdog
  localparam int RANDOM_PERIODS = 1240;
  localparam int LIMIT_CYCLES   = 200000;
  // idling phase changes after this many random periods
  localparam int STAGE_PERIODS  = 210;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       cmd_valid_i;
  logic [1:0] mode_i;
  logic [7:0] tx_byte_i;
  logic [7:0] period_count_i;
  logic       line_in_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       drive_enable_o;
  logic       line_out_o;
  logic       clock_active_o;
  logic       ready_res_o;
  logic       rx_valid_o;
  logic [7:0] rx_byte_o;
  logic [1:0] rx_status_o;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int period_total = 0;
  // current idling mix, in percent per cycle
  int send_gap_pct = 0;
  int sink_stall_pct = 0;

  sync_serial_8e2_frame_phy_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_valid_i    (cmd_valid_i),
    .mode_i         (mode_i),
    .tx_byte_i      (tx_byte_i),
    .period_count_i (period_count_i),
    .line_in_i      (line_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_enable_o (drive_enable_o),
    .line_out_o     (line_out_o),
    .clock_active_o (clock_active_o),
    .ready_res_o    (ready_res_o),
    .rx_valid_o     (rx_valid_o),
    .rx_byte_o      (rx_byte_o),
    .rx_status_o    (rx_status_o)
  );

  // predicts and compares every transaction on both channels
  ss8e2_link_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .cmd_valid_i    (cmd_valid_i),
    .mode_i         (mode_i),
    .tx_byte_i      (tx_byte_i),
    .period_count_i (period_count_i),
    .line_in_i      (line_in_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_enable_i (drive_enable_o),
    .line_out_i     (line_out_o),
    .clock_active_i (clock_active_o),
    .ready_res_i    (ready_res_o),
    .rx_valid_i     (rx_valid_o),
    .rx_byte_i      (rx_byte_o),
    .rx_status_i    (rx_status_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random back-pressure at the current stall rate
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // one bit period as one input transaction; may idle first, then holds
  // valid and payload until the engine takes it
  task automatic offer_period(input logic cmd, input mode_e md, input logic [7:0] data,
                              input logic [7:0] cnt, input logic line);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_valid_i    <= cmd;
    mode_i         <= md;
    tx_byte_i      <= data;
    period_count_i <= cnt;
    line_in_i      <= line;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    period_total++;
  endtask

  // period while the engine is busy; sometimes carries a command that
  // must be ignored
  task automatic offer_busy(input int noise_pct, input logic line);
    offer_period($urandom_range(99) < noise_pct, mode_e'($urandom_range(3)),
                 8'($urandom), 8'($urandom), line);
  endtask

  task automatic idle_periods(input int n);
    repeat (n) offer_period(1'b0, mode_e'($urandom_range(3)), 8'($urandom),
                            8'($urandom), 1'($urandom_range(1)));
  endtask

  // send command plus the rest of the 12-bit frame
  task automatic run_send(input logic [7:0] data, input int noise_pct);
    offer_period(1'b1, MODE_SEND, data, 8'($urandom), 1'($urandom_range(1)));
    repeat (SEND_BITS - 1) offer_busy(noise_pct, 1'($urandom_range(1)));
  endtask

  // break or idle for cnt periods; zero count is a single period
  task automatic run_hold(input mode_e md, input logic [7:0] cnt, input int noise_pct);
    offer_period(1'b1, md, 8'($urandom), cnt, 1'($urandom_range(1)));
    for (int i = 1; i < cnt; i++) offer_busy(noise_pct, 1'($urandom_range(1)));
  endtask

  // receive: hunt ones, start bit, then data lsb first, parity, two stops
  task automatic run_receive(input int hunt, input logic [7:0] data, input logic flip_parity,
                             input logic [1:0] stops, input int noise_pct);
    logic [10:0] frame;
    frame = {stops[1], stops[0], (^data) ^ flip_parity, data};
    offer_period(1'b1, MODE_RECV, 8'($urandom), 8'($urandom), hunt != 0);
    for (int k = 1; k <= hunt; k++) offer_busy(noise_pct, k != hunt);
    for (int i = 0; i < CAPTURE_BITS; i++) offer_busy(noise_pct, frame[i]);
  endtask

  // sender holds off until every expected result has been taken
  task automatic drain_link();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(input int stage);
    case (stage % 4)
      0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
      1: begin send_gap_pct = 73; sink_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  sink_stall_pct = 73; end
      default: begin send_gap_pct = 17; sink_stall_pct = 17; end
    endcase
  endtask

  initial begin
    int          random_base;
    int          stage;
    int          pick;
    logic        broken;
    logic [7:0]  cnt;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    cmd_valid_i    <= 1'b0;
    mode_i         <= MODE_IDLE;
    tx_byte_i      <= 8'd0;
    period_count_i <= 8'd0;
    line_in_i      <= 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: line after reset, frames at the byte extremes
    idle_periods(2);
    run_send(8'h00, 0);
    run_send(8'hff, 0);
    run_send(8'h80, 0);
    // commands offered mid-frame are dropped
    run_send(8'ha5, 100);
    idle_periods(2);
    // zero count sets the level without clocking
    run_hold(MODE_BREAK, 8'd0, 0);
    idle_periods(1);
    run_hold(MODE_IDLE, 8'd0, 0);
    run_hold(MODE_BREAK, 8'd1, 0);
    run_hold(MODE_IDLE, 8'd3, 0);
    run_hold(MODE_BREAK, 8'd255, 0);
    // receive: immediate start, long hunt, then the released line
    run_receive(0, 8'h3c, 1'b0, 2'b11, 0);
    run_receive(5, 8'hff, 1'b0, 2'b11, 100);
    idle_periods(2);
    // bad first stop, bad second stop, bad parity, framing over parity
    run_receive(1, 8'h5a, 1'b0, 2'b10, 0);
    run_receive(0, 8'h01, 1'b0, 2'b01, 0);
    run_receive(2, 8'h7e, 1'b1, 2'b11, 0);
    run_receive(0, 8'hc3, 1'b1, 2'b00, 0);
    drain_link();
    run_hold(MODE_IDLE, 8'd2, 0);
    run_send(8'h00, 0);

    // random part, idling mix rotates with a full drain at each change
    random_base = period_total;
    stage = 0;
    set_idling(stage);
    while (period_total - random_base < RANDOM_PERIODS) begin
      if ((period_total - random_base) / STAGE_PERIODS != stage) begin
        stage = (period_total - random_base) / STAGE_PERIODS;
        drain_link();
        set_idling(stage);
      end
      pick = $urandom_range(99);
      if (pick < 30) begin
        run_send(8'($urandom), 10);
      end else if (pick < 60) begin
        // mostly clean frames, a quarter with random damage
        broken = ($urandom_range(99) < 25);
        run_receive($urandom_range(0, 3), 8'($urandom),
                    broken & 1'($urandom_range(1)),
                    broken ? 2'($urandom) : 2'b11, 10);
      end else if (pick < 75) begin
        pick = $urandom_range(99);
        if (pick < 85)      cnt = 8'($urandom_range(0, 8));
        else if (pick < 97) cnt = 8'($urandom_range(0, 255));
        else                cnt = 8'd255;
        run_hold($urandom_range(1) ? MODE_IDLE : MODE_BREAK, cnt, 10);
      end else if (pick < 88) begin
        idle_periods($urandom_range(1, 3));
      end else begin
        // raw noise, then enough quiet periods to let the engine settle
        repeat ($urandom_range(1, 4))
          offer_period(1'($urandom_range(1)), mode_e'($urandom_range(3)), 8'($urandom),
                       8'($urandom_range(0, 15)), 1'($urandom_range(1)));
        idle_periods(28);
      end
    end

    // let every result out, then wait for stray ones
    drain_link();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
